// ===== rtl/core/smfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfp_pkg
// Shared widths, operation and status codes, and controller/datapath
// handshake structs for the seat map farthest-placement block.
// ----------------------------------------------------------------------------
package smfp_pkg;

   localparam int MAX_SEATS = 64;
   localparam int FUNC_W    = 3;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int MAP_W     = 64;
   localparam int DIST_W    = 7;
   localparam int STAT_W    = 2;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_SEATS);

   typedef enum logic [FUNC_W-1:0] {
      FN_QUERY  = 3'd0,
      FN_OCCUPY = 3'd1,
      FN_VACATE = 3'd2,
      FN_DIST   = 3'd3,
      FN_FIND   = 3'd4,
      FN_LOAD   = 3'd5
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_SAME     = 2'd2,
      ST_NO_EMPTY = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch the accepted word
      logic exec_write;  // apply a single-step operation and load the result
      logic scan_start;  // clear the scan registers
      logic scan_step;   // examine one slot
      logic scan_write;  // load the scan result
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_scan;
      logic scan_last;
      logic out_free;
   } ctl_sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/smfp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfp_datapath
// Occupancy map, slot count register, slot scanner and result register.
// ----------------------------------------------------------------------------
module smfp_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [smfp_pkg::CNT_W-1:0]    csr_wr_data,
   input  wire logic [smfp_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [smfp_pkg::IDX_W-1:0]    req_seat_index,
   input  wire logic [smfp_pkg::MAP_W-1:0]    req_load_map,
   input  wire logic                          rsp_stall,
   input  wire smfp_pkg::ctl_cmd_type         cmd,
   output smfp_pkg::ctl_sts_type              sts,
   output logic                               rsp_valid,
   output logic [smfp_pkg::STAT_W-1:0]        rsp_status,
   output logic                               rsp_seat_state,
   output logic [smfp_pkg::DIST_W-1:0]        rsp_distance,
   output logic [smfp_pkg::IDX_W-1:0]         rsp_chosen_seat
);
   import smfp_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MAP_W-1:0]  occ_ff, occ_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_vld_ff, last_vld_in;

   logic [FUNC_W-1:0] func_ff, func_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [MAP_W-1:0]  map_ff, map_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [IDX_W-1:0]  best_s_ff, best_s_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              state_ff, state_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [IDX_W-1:0]  chosen_ff, chosen_in;

   logic [CNT_W-1:0]  n_eff;
   logic [CNT_W-1:0]  n_last_w;
   logic [IDX_W-1:0]  n_last;
   logic [MAP_W-1:0]  mask;
   logic              map_any;
   logic              in_range;
   logic              cur_bit;
   logic              scan_bit;

   logic [STAT_W-1:0] imm_status;
   logic              imm_state;
   logic [DIST_W-1:0] imm_dist;
   logic [MAP_W-1:0]  imm_occ;
   logic              needs_scan;

   logic [IDX_W-1:0]  gap;
   logic [IDX_W-1:0]  half;
   logic              cand_ok;
   logic [DIST_W-1:0] cand_d;
   logic [IDX_W-1:0]  cand_s;

   logic              tail_ok;
   logic [DIST_W-1:0] tail_d;
   logic [IDX_W-1:0]  tail_s;
   logic [DIST_W-1:0] fin_d;
   logic [IDX_W-1:0]  fin_s;
   logic [DIST_W-1:0] left_d;
   logic [STAT_W-1:0] scan_status;
   logic [DIST_W-1:0] scan_dist;
   logic [IDX_W-1:0]  scan_chosen;
   logic              out_free;

   // effective slot count, saturated into 1..MAX_SEATS
   always_comb begin
      priority if (count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_SEATS)) begin
         n_eff = CNT_W'(MAX_SEATS);
      end else begin
         n_eff = count_ff;
      end
   end

   assign n_last_w = n_eff - CNT_W'(1);
   assign n_last   = n_last_w[IDX_W-1:0];

   always_comb begin
      for (int b = 0; b < MAP_W; b++) begin
         mask[b] = (CNT_W'(b) < n_eff);
      end
   end

   assign map_any  = |(occ_ff & mask);
   assign in_range = ({1'b0, idx_ff} < n_eff);
   // slot i lives at bit n-1-i
   assign cur_bit  = occ_ff[n_last - idx_ff];
   assign scan_bit = occ_ff[n_last - pos_ff];

   // single-step operations
   always_comb begin
      imm_status = ST_OK;
      imm_state  = 1'b0;
      imm_dist   = '0;
      imm_occ    = occ_ff;
      needs_scan = 1'b0;
      unique case (func_ff)
         FN_QUERY, FN_OCCUPY, FN_VACATE, FN_DIST: begin
            if (!in_range) begin
               imm_status = ST_RANGE;
            end else begin
               imm_state = cur_bit;
               unique case (func_ff)
                  FN_OCCUPY: begin
                     if (cur_bit) begin
                        imm_status = ST_SAME;
                     end else begin
                        imm_occ[n_last - idx_ff] = 1'b1;
                        imm_state = 1'b1;
                     end
                  end
                  FN_VACATE: begin
                     if (!cur_bit) begin
                        imm_status = ST_SAME;
                     end else begin
                        imm_occ[n_last - idx_ff] = 1'b0;
                        imm_state = 1'b0;
                     end
                  end
                  FN_DIST: begin
                     if (!cur_bit) begin
                        if (map_any) begin
                           needs_scan = 1'b1;
                        end else begin
                           imm_dist = n_eff;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FN_FIND: begin
            needs_scan = 1'b1;
         end
         FN_LOAD: begin
            imm_occ = map_ff & mask;
         end
         default: begin
         end
      endcase
   end

   // candidate from the run of empty slots that ends at the current slot
   assign gap  = pos_ff - last_ff;
   assign half = gap >> 1;
   always_comb begin
      if (!last_vld_ff) begin
         cand_ok = scan_bit && (pos_ff != '0);
         cand_d  = {1'b0, pos_ff};
         cand_s  = '0;
      end else begin
         cand_ok = scan_bit && (gap >= IDX_W'(2));
         cand_d  = {1'b0, half};
         cand_s  = last_ff + half;
      end
   end

   // trailing run after the last occupied slot, or the whole map if empty
   always_comb begin
      if (last_vld_ff) begin
         tail_ok = (last_ff != n_last);
         tail_d  = {1'b0, n_last - last_ff};
         tail_s  = n_last;
      end else begin
         tail_ok = 1'b1;
         tail_d  = n_eff;
         tail_s  = '0;
      end
      if (tail_ok && (tail_d > best_d_ff)) begin
         fin_d = tail_d;
         fin_s = tail_s;
      end else begin
         fin_d = best_d_ff;
         fin_s = best_s_ff;
      end
   end

   assign left_d = {1'b0, idx_ff - last_ff};

   always_comb begin
      if (func_ff == FN_FIND) begin
         scan_status = (fin_d == '0) ? ST_NO_EMPTY : ST_OK;
         scan_dist   = fin_d;
         scan_chosen = (fin_d == '0) ? '0 : fin_s;
      end else begin
         scan_status = ST_OK;
         scan_chosen = '0;
         if (last_vld_ff && ((best_d_ff == '0) || (left_d < best_d_ff))) begin
            scan_dist = left_d;
         end else begin
            scan_dist = best_d_ff;
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next-state logic
   always_comb begin
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      occ_in       = cmd.exec_write ? imm_occ : occ_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.exec_write || cmd.scan_write) begin
         rsp_valid_in = 1'b1;
      end

      func_in   = cmd.capture ? req_func : func_ff;
      idx_in    = cmd.capture ? req_seat_index : idx_ff;
      map_in    = cmd.capture ? req_load_map : map_ff;

      pos_in      = pos_ff;
      last_in     = last_ff;
      last_vld_in = last_vld_ff;
      best_d_in   = best_d_ff;
      best_s_in   = best_s_ff;
      if (cmd.scan_start) begin
         pos_in      = '0;
         last_vld_in = 1'b0;
         best_d_in   = '0;
         best_s_in   = '0;
      end else if (cmd.scan_step) begin
         pos_in = pos_ff + IDX_W'(1);
         if (func_ff == FN_FIND) begin
            if (cand_ok && (cand_d > best_d_ff)) begin
               best_d_in = cand_d;
               best_s_in = cand_s;
            end
            if (scan_bit) begin
               last_in     = pos_ff;
               last_vld_in = 1'b1;
            end
         end else if (scan_bit) begin
            // distance: keep nearest occupied on the left, first on the right
            if (pos_ff < idx_ff) begin
               last_in     = pos_ff;
               last_vld_in = 1'b1;
            end else if (best_d_ff == '0) begin
               best_d_in = {1'b0, pos_ff - idx_ff};
            end
         end
      end

      status_in = status_ff;
      state_in  = state_ff;
      dist_in   = dist_ff;
      chosen_in = chosen_ff;
      if (cmd.exec_write) begin
         status_in = imm_status;
         state_in  = imm_state;
         dist_in   = imm_dist;
         chosen_in = '0;
      end else if (cmd.scan_write) begin
         status_in = scan_status;
         state_in  = 1'b0;
         dist_in   = scan_dist;
         chosen_in = scan_chosen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_vld_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         last_vld_ff  <= last_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      idx_ff    <= idx_in;
      map_ff    <= map_in;
      pos_ff    <= pos_in;
      last_ff   <= last_in;
      best_d_ff <= best_d_in;
      best_s_ff <= best_s_in;
      status_ff <= status_in;
      state_ff  <= state_in;
      dist_ff   <= dist_in;
      chosen_ff <= chosen_in;
   end

   assign sts.needs_scan = needs_scan;
   assign sts.scan_last  = (pos_ff == n_last);
   assign sts.out_free   = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_seat_state  = state_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_chosen_seat = chosen_ff;

endmodule
`default_nettype wire

// ===== rtl/core/smfp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfp_ctrl
// Sequencer: accepts a word, runs the single-step or scanning path and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module smfp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire smfp_pkg::ctl_sts_type  sts,
   output smfp_pkg::ctl_cmd_type       cmd
);
   import smfp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FINISH
   } fsm_type;

   fsm_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.needs_scan) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else if (sts.out_free) begin
               cmd.exec_write = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.scan_write = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/seat_map_farthest_placement.sv =====
`default_nettype none
// Query, occupy, vacate, load and trivial distance words are captured, then written to the
//   result register from the execute state; find and scanned distance words scan all n slots,
//   n = effective slot count, and are written from the finish state. One word at a time; the
//   scanner examines one slot per cycle, and a result write waits while the output register is held.
// Reset (synchronous, active high): all slots empty, slot count 64, no result pending.
// ----------------------------------------------------------------------------
// seat_map_farthest_placement
// Occupancy map of up to 64 slots with query, occupy, vacate, distance,
// farthest-empty-slot search and whole-map load.
// ----------------------------------------------------------------------------
module seat_map_farthest_placement (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [smfp_pkg::CNT_W-1:0]    csr_wr_data,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [smfp_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [smfp_pkg::IDX_W-1:0]    req_seat_index,
   input  wire logic [smfp_pkg::MAP_W-1:0]    req_load_map,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [smfp_pkg::STAT_W-1:0]        rsp_status,
   output logic                               rsp_seat_state,
   output logic [smfp_pkg::DIST_W-1:0]        rsp_distance,
   output logic [smfp_pkg::IDX_W-1:0]         rsp_chosen_seat
);
   import smfp_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // The controller takes a word only from its idle state; the word then
   // runs through one of two paths:
   //  - single step: the outcome follows from the range check, the addressed
   //    bit, the map-empty test or the loaded map, and goes straight to the output register.
   //  - scan: slots are examined in order, one per cycle. A find tracks the
   //    runs of empty slots between occupied ones: the middle of each run is
   //    its farthest slot, a leading run favors slot 0 and a trailing run
   //    the last slot. A distance scan keeps the nearest occupied slot on
   //    either side of the addressed one.
   // The output register decouples the two channels: a new word may be
   // accepted while the previous result still waits; its result holds in
   // the datapath until the register frees up.
   smfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   smfp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_func        (req_func),
      .req_seat_index  (req_seat_index),
      .req_load_map    (req_load_map),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_seat_state  (rsp_seat_state),
      .rsp_distance    (rsp_distance),
      .rsp_chosen_seat (rsp_chosen_seat)
   );

   // an accepted word blocks the request side on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open right after an accepted word");

   // a failed find reports neither a distance nor a slot
   a_no_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NO_EMPTY)) |->
         ((rsp_distance == '0) && (rsp_chosen_seat == '0)))
      else $error("no-empty status with nonzero distance or slot");

   // an out-of-range word reports no slot data
   a_range_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_RANGE)) |->
         (!rsp_seat_state && (rsp_distance == '0) && (rsp_chosen_seat == '0)))
      else $error("out-of-range status with slot data");

   // distance never exceeds the slot capacity
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance <= DIST_W'(MAX_SEATS)))
      else $error("distance beyond slot capacity");

endmodule
`default_nettype wire
